### sv/lsf_pkg.sv
// Package for the line substring filter: widths, register indexes and helpers.
// Used by the channel interfaces and by the top level line_substring_filter_unit.
`default_nettype none

package lsf_pkg;

  // Longest pattern the window can hold (lengths 0 to 16)
  localparam int PATTERN_MAX = 16;
  // Pattern bytes held by the two 64-bit pattern registers
  localparam int PATTERN_BYTES = 16;
  localparam int PAT_IDX_W = $clog2(PATTERN_BYTES);
  // Width of a line byte count that saturates at PATTERN_MAX
  localparam int COUNT_W = $clog2(PATTERN_MAX + 1);
  localparam int LEN_REG_W = 5;
  localparam int TOTAL_W = 32;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 64;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CASE_INSENSITIVE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH     = 8'd3;

  // Line terminators and case-fold constants
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Fold ASCII lower case to upper when enabled
  function automatic logic [7:0] fold_byte(input logic en, input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (en && b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
      r = b - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/lsf_intf.sv
// Valid/ready channel interfaces for the line substring filter.
// Depends on lsf_pkg for field widths.
`default_nettype none

// Text byte channel
interface lsf_text_if import lsf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

// Per-line result channel
interface lsf_result_if import lsf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               line_matched;
  logic [TOTAL_W-1:0] matched_line_count;
  logic               stream_done;

  modport source (output valid, output line_matched, output matched_line_count,
                  output stream_done, input ready);
  modport sink   (input valid, input line_matched, input matched_line_count,
                  input stream_done, output ready);
endinterface

// Register write channel
interface lsf_cfg_if import lsf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/line_substring_filter_unit.sv
// Top level of the line substring filter: input register, window compare, result register.
// Depends on lsf_pkg and the channel interfaces in lsf_intf.sv.
`default_nettype none

// Takes one text byte per transaction and reports, for every non-empty line, whether
// the line contained the configured pattern, plus the saturating count of matched lines
// in the current stream. Newline, NUL or end_of_input closes a line; empty lines give
// no result. A byte is accepted every cycle while the result side keeps up: it is held in
// the input register, where the shifted window is compared against all pattern positions
// in parallel, and when the input register advances, a closing byte moves the line's result
// into the output register, from which it can be taken. The input stalls only while the
// output register holds a result that has not been taken. Registers are written through
// the cfg channel, which is always ready; write them only while the block is idle.

module line_substring_filter_unit
  import lsf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  lsf_text_if.sink    text_in,
  lsf_result_if.source result_out,
  lsf_cfg_if.sink     cfg
);

  // Configuration registers
  logic                 case_insensitive;
  logic [LEN_REG_W-1:0] pattern_length;
  logic [63:0]          pattern_low;
  logic [63:0]          pattern_high;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_insensitive <= 1'b0;
      pattern_length   <= '0;
      pattern_low      <= '0;
      pattern_high     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CASE_INSENSITIVE: case_insensitive <= cfg.data[0];
        REG_PATTERN_LENGTH:   pattern_length   <= cfg.data[LEN_REG_W-1:0];
        REG_PATTERN_LOW:      pattern_low      <= cfg.data;
        REG_PATTERN_HIGH:     pattern_high     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input stage and output register
  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               s1_eoi;
  logic               s1_advance;

  logic               out_valid;
  logic               out_matched;
  logic [TOTAL_W-1:0] out_count;
  logic               out_done;

  assign s1_advance    = !out_valid || result_out.ready;
  assign text_in.ready = !s1_valid || s1_advance;

  // Line state
  logic [7:0]         window [PATTERN_MAX];
  logic [COUNT_W-1:0] bytes_in_line;
  logic               line_has_match;
  logic [TOTAL_W-1:0] match_total;

  // Active length, clamped to the window depth
  logic [COUNT_W-1:0] active_len;
  always_comb begin
    if (pattern_length > LEN_REG_W'(PATTERN_MAX)) begin
      active_len = COUNT_W'(PATTERN_MAX);
    end else begin
      active_len = COUNT_W'(pattern_length);
    end
  end

  // Folded pattern bytes
  logic [7:0] pat [PATTERN_BYTES];
  always_comb begin
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      if (k < 8) begin
        pat[k] = fold_byte(case_insensitive, pattern_low[k*8 +: 8]);
      end else begin
        pat[k] = fold_byte(case_insensitive, pattern_high[(k-8)*8 +: 8]);
      end
    end
  end

  // Shifted window and compare; window entry j pairs with pattern byte len-1-j
  logic               s1_is_end;
  logic [7:0]         win_next [PATTERN_MAX];
  logic [COUNT_W-1:0] bytes_next;
  logic               window_hit;
  logic [LEN_REG_W:0] pidx_wide [PATTERN_MAX];

  assign s1_is_end = s1_eoi || s1_byte == CHAR_NEWLINE || s1_byte == CHAR_NUL;

  always_comb begin
    win_next[0] = s1_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win_next[j] = window[j-1];
    end
    if (bytes_in_line < COUNT_W'(PATTERN_MAX)) begin
      bytes_next = bytes_in_line + COUNT_W'(1);
    end else begin
      bytes_next = bytes_in_line;
    end
    window_hit = bytes_next >= active_len;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pidx_wide[j] = (LEN_REG_W+1)'(active_len) - (LEN_REG_W+1)'(1) - (LEN_REG_W+1)'(j);
      if (COUNT_W'(j) < active_len &&
          fold_byte(case_insensitive, win_next[j]) != pat[pidx_wide[j][PAT_IDX_W-1:0]]) begin
        window_hit = 1'b0;
      end
    end
  end

  // Saturating count including this line
  logic [TOTAL_W-1:0] total_next;
  always_comb begin
    if (line_has_match && match_total != '1) begin
      total_next = match_total + TOTAL_W'(1);
    end else begin
      total_next = match_total;
    end
  end

  // Window shift register (payload, no reset)
  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance && !s1_is_end) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        window[j] <= win_next[j];
      end
    end
  end

  // Input register, line state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      bytes_in_line  <= '0;
      line_has_match <= 1'b0;
      match_total    <= '0;
    end else begin
      if (text_in.ready) begin
        s1_valid <= text_in.valid;
      end
      // a new result takes the slot; otherwise a taken result frees it
      if (s1_valid && s1_advance && s1_is_end && bytes_in_line != '0) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      if (s1_valid && s1_advance) begin
        if (!s1_is_end) begin
          bytes_in_line <= bytes_next;
          if (window_hit) begin
            line_has_match <= 1'b1;
          end
        end else if (bytes_in_line == '0) begin
          if (s1_eoi) begin
            match_total <= '0;
          end
        end else begin
          bytes_in_line  <= '0;
          line_has_match <= 1'b0;
          match_total    <= s1_eoi ? '0 : total_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (text_in.ready && text_in.valid) begin
      s1_byte <= text_in.text_byte;
      s1_eoi  <= text_in.end_of_input;
    end
    if (s1_valid && s1_advance && s1_is_end && bytes_in_line != '0) begin
      out_matched <= line_has_match;
      out_count   <= total_next;
      out_done    <= s1_eoi;
    end
  end

  assign result_out.valid              = out_valid;
  assign result_out.line_matched       = out_matched;
  assign result_out.matched_line_count = out_count;
  assign result_out.stream_done        = out_done;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for line_substring_filter_unit: a clocked driver and monitor
// with a line-matching predictor, run through several pattern setups and idling mixes.
// Depends on lsf_pkg, the channel interfaces in lsf_intf.sv and the unit itself.

module tb;
  import lsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 122;
  localparam int unsigned NUM_PHASES = 7;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } text_item_t;

  typedef struct packed {
    logic               line_matched;
    logic [TOTAL_W-1:0] matched_line_count;
    logic               stream_done;
  } line_result_t;

  // Symbols around the case-fold boundaries: a z A Z ` { @ [
  localparam logic [7:0] SYMBOLS [8] = '{8'h61, 8'h7A, 8'h41, 8'h5A, 8'h60, 8'h7B, 8'h40, 8'h5B};

  logic clk = 1'b0;
  logic rst;

  lsf_text_if   text_ch ();
  lsf_result_if res_ch ();
  lsf_cfg_if    cfg_ch ();

  line_substring_filter_unit dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_ch),
    .result_out (res_ch),
    .cfg        (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus and expected results
  text_item_t   byte_queue [$];
  line_result_t due_results [$];
  text_item_t   on_wire;
  line_result_t oldest;

  // Predictor copy of the registers and the line state
  logic                  case_fold;
  logic [LEN_REG_W-1:0]  pat_len;
  logic [127:0]          pattern;
  logic [7:0]            line_window [PATTERN_MAX];
  int unsigned           line_fill;
  logic                  line_hit;
  logic [TOTAL_W-1:0]    hit_total;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned phase_items;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned lines_matched;
  int unsigned streams_closed;
  int unsigned reg_writes;

  function automatic logic [7:0] upcase(input logic [7:0] b);
    if (case_fold && b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
    return b;
  endfunction

  function automatic int unsigned active_len();
    return (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
  endfunction

  function automatic void clear_line();
    int i;
    for (i = 0; i < PATTERN_MAX; i++) line_window[i] = 8'h00;
    line_fill = 0;
    line_hit = 1'b0;
  endfunction

  // Advance the line state by one accepted byte; queue a result when a line closes
  function automatic void filter_byte(input text_item_t it);
    line_result_t r;
    int unsigned len;
    int unsigned k;
    int i;
    logic hit;
    len = active_len();
    if (!it.end_of_input && it.text_byte != CHAR_NEWLINE && it.text_byte != CHAR_NUL) begin
      for (i = PATTERN_MAX - 1; i > 0; i--) line_window[i] = line_window[i-1];
      line_window[0] = it.text_byte;
      if (line_fill < PATTERN_MAX) line_fill++;
      // window entry len-1 is the oldest, it lines up with pattern byte 0
      hit = (line_fill >= len);
      for (k = 0; k < len; k++) begin
        if (upcase(line_window[len-1-k]) != upcase(pattern[8*k +: 8])) hit = 1'b0;
      end
      if (hit) line_hit = 1'b1;
    end else if (line_fill == 0) begin
      // empty line: nothing reported, end of input still restarts the stream
      if (it.end_of_input) hit_total = '0;
    end else begin
      if (line_hit && hit_total != '1) hit_total++;
      r.line_matched = line_hit;
      r.matched_line_count = hit_total;
      r.stream_done = it.end_of_input;
      due_results.push_back(r);
      clear_line();
      if (it.end_of_input) hit_total = '0;
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic eoi);
    text_item_t it;
    it.text_byte = b;
    it.end_of_input = eoi;
    byte_queue.push_back(it);
    phase_items++;
  endfunction

  // Mostly fold-boundary symbols, now and then any byte except newline and NUL
  function automatic logic [7:0] line_char();
    logic [7:0] b;
    if ($urandom_range(9) != 0) return SYMBOLS[$urandom_range(7)];
    b = 8'($urandom_range(255, 1));
    if (b == CHAR_NEWLINE) b = 8'h0B;
    return b;
  endfunction

  // One line: prefix, maybe the pattern with random case flips, suffix, terminator; or a noise burst
  function automatic void queue_line();
    int unsigned pre;
    int unsigned post;
    int unsigned k;
    logic [7:0] b;
    if ($urandom_range(99) < 8) begin
      // noise burst of arbitrary bytes, terminators included
      repeat ($urandom_range(12, 1)) queue_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
      return;
    end
    if ($urandom_range(9) != 0) begin
      pre = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(6);
      post = $urandom_range(6);
      repeat (pre) queue_byte(line_char(), 1'b0);
      if ($urandom_range(1)) begin
        for (k = 0; k < active_len(); k++) begin
          b = pattern[8*k +: 8];
          if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(3) == 0)
            b = b ^ 8'h20;
          queue_byte(b, 1'b0);
        end
      end
      repeat (post) queue_byte(line_char(), 1'b0);
    end
    case ($urandom_range(19))
      0, 1, 2: queue_byte(CHAR_NUL, 1'b0);
      3, 4:    queue_byte(8'($urandom_range(255)), 1'b1);
      default: queue_byte(CHAR_NEWLINE, 1'b0);
    endcase
  endfunction

  // Wait until every byte is taken and every result is back, then let the pipe empty
  task automatic settle();
    do @(negedge clk); while (byte_queue.size() != 0 || text_ch.valid || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; valid stays up between back-to-back writes
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_CASE_INSENSITIVE: case_fold = val[0];
      REG_PATTERN_LENGTH:   pat_len = val[LEN_REG_W-1:0];
      REG_PATTERN_LOW:      pattern[63:0] = val;
      REG_PATTERN_HIGH:     pattern[127:64] = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Text driver: takes the next byte from the queue unless idling
  always @(posedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        filter_byte(on_wire);
        bytes_sent++;
      end
      if (!text_ch.valid || text_ch.ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = byte_queue.pop_front();
          text_ch.valid        <= 1'b1;
          text_ch.text_byte    <= on_wire.text_byte;
          text_ch.end_of_input <= on_wire.end_of_input;
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transaction with the oldest expected line result
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("result with no line pending: line_matched %0d, count %0d, stream_done %0d",
                 res_ch.line_matched, res_ch.matched_line_count, res_ch.stream_done);
          mismatches++;
        end else begin
          oldest = due_results.pop_front();
          if (res_ch.line_matched !== oldest.line_matched) begin
            $error("line_matched: expected %0d, got %0d", oldest.line_matched,
                   res_ch.line_matched);
            mismatches++;
          end
          if (res_ch.matched_line_count !== oldest.matched_line_count) begin
            $error("matched_line_count: expected %0d, got %0d", oldest.matched_line_count,
                   res_ch.matched_line_count);
            mismatches++;
          end
          if (res_ch.stream_done !== oldest.stream_done) begin
            $error("stream_done: expected %0d, got %0d", oldest.stream_done,
                   res_ch.stream_done);
            mismatches++;
          end
          results_seen++;
          if (oldest.line_matched) lines_matched++;
          if (oldest.stream_done) streams_closed++;
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Phase sequencing
  initial begin
    int unsigned p;
    int unsigned len;
    int unsigned k;
    logic fold;
    logic [127:0] pat;
    logic [CFG_DATA_W-1:0] junk;
    int unsigned lens [NUM_PHASES+1];
    logic folds [NUM_PHASES+1];

    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.text_byte = 8'h00;
    text_ch.end_of_input = 1'b0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    case_fold = 1'b0;
    pat_len = '0;
    pattern = '0;
    hit_total = '0;
    clear_line();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    phase_items = 0;
    cycle_count = 0;
    mismatches = 0;
    bytes_sent = 0;
    results_seen = 0;
    lines_matched = 0;
    streams_closed = 0;
    reg_writes = 0;
    // 16 is the longest pattern, 31 must clip to 16, 5 carries a zero pattern byte
    lens = '{0, 3, 16, 31, 1, 0, 5, 0};
    folds = '{0, 0, 1, 1, 0, 1, 0, 0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pattern after reset, so every non-empty line matches
    queue_byte(8'h61, 1'b0);          queue_byte(CHAR_NEWLINE, 1'b0);
    queue_byte(CHAR_NEWLINE, 1'b0);   // empty line, no result
    queue_byte(8'hFF, 1'b0);          queue_byte(8'h80, 1'b0);
    queue_byte(CHAR_NUL, 1'b0);
    queue_byte(8'h55, 1'b1);          // end of input on an empty line restarts the count
    queue_byte(8'h01, 1'b0);          queue_byte(CHAR_NEWLINE, 1'b1);
    queue_byte(8'h7F, 1'b0);          queue_byte(8'h00, 1'b1);
    queue_byte(CHAR_NUL, 1'b0);       queue_byte(8'hAA, 1'b1);
    settle();

    for (p = 1; p <= NUM_PHASES; p++) begin
      len = (p >= 7) ? $urandom_range(31) : lens[p];
      fold = (p >= 7) ? 1'($urandom_range(1)) : folds[p];
      for (k = 0; k < 16; k++) pat[8*k +: 8] = SYMBOLS[$urandom_range(7)];
      if (p == 6) pat[15:8] = CHAR_NUL;
      if (p == 7 && $urandom_range(1)) pat = {$urandom, $urandom, $urandom, $urandom};
      // unused upper bits of the narrow registers carry junk
      junk = {$urandom, $urandom};
      write_reg(REG_CASE_INSENSITIVE, {junk[63:1], fold});
      junk = {$urandom, $urandom};
      write_reg(REG_PATTERN_LENGTH, {junk[63:LEN_REG_W], len[LEN_REG_W-1:0]});
      write_reg(REG_PATTERN_LOW, pat[63:0]);
      write_reg(REG_PATTERN_HIGH, pat[127:64]);
      // unmapped index, must leave everything alone
      write_reg(CFG_INDEX_W'((p == 1) ? 255 : REG_PATTERN_HIGH + 1 + $urandom_range(251)),
                {$urandom, $urandom});
      cfg_ch.valid <= 1'b0;

      case (p % 4)
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        3: begin send_idle_pct = 34; recv_stall_pct = 34; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase

      // two halves, the sender holding off until the first half is fully answered
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE / 2) queue_line();
      settle();
      while (phase_items < ITEMS_PER_PHASE) queue_line();
      settle();
    end

    $display("Sent %0d text bytes over %0d register setups (%0d register writes).",
             bytes_sent, NUM_PHASES + 1, reg_writes);
    $display("Checked %0d line results: %0d matched, %0d closed a stream.",
             results_seen, lines_matched, streams_closed);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### line_substring_filter_unit.f
sv/lsf_pkg.sv
sv/lsf_intf.sv
sv/line_substring_filter_unit.sv
tb/tb.sv
